// File: sv/mexp_pkg.sv
// shared types and constants for the modular exponentiation block
package mexp_pkg;

    localparam int DATA_W    = 64;
    localparam int DEF_WIDTH = 64;

    typedef struct packed {
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] exponent;
        logic [DATA_W-1:0] modulus;
    } t_in_word;

    typedef struct packed {
        logic [DATA_W-1:0] power;
        logic              bad_modulus;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic red_step;
        logic mul_step;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic mod_zero;
        logic exp_zero;
        logic exp_last;
        logic pass_end;
    } t_dp_stat;

endpackage

// File: sv/mexp_ctrl.sv
// sequencer for load, reduction pass, square-and-multiply passes and result handoff
module mexp_ctrl import mexp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    output logic     o_valid,
    input  logic     i_ready,
    input  t_dp_stat i_stat,
    output t_ctl_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RED  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RED;
                end
            end
            S_RED: begin
                if (i_stat.mod_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.red_step = 1'b1;
                    if (i_stat.pass_end) begin
                        n_state = i_stat.exp_zero ? S_DONE : S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.pass_end && i_stat.exp_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// File: sv/mexp_dpath.sv
// operand registers, two interleaved mod-multiply lanes and the result word register
module mexp_dpath import mexp_pkg::*; #(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic      i_clk,
    input  t_in_word  i_data,
    input  t_ctl_cmd  i_cmd,
    output t_dp_stat  o_stat,
    output t_out_word o_data
);

    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0]  r_base;
    logic [WIDTH-1:0]  r_mod;
    logic [WIDTH-1:0]  r_res;
    logic [WIDTH-1:0]  r_ysh;
    logic [WIDTH-1:0]  r_acc_a;
    logic [WIDTH-1:0]  r_acc_b;
    logic [DATA_W-1:0] r_exp;
    logic [CW-1:0]     r_cnt;
    logic              r_err;
    t_out_word         r_out;

    logic [WIDTH-1:0]  x_a;
    logic [WIDTH-1:0]  nxt_a;
    logic [WIDTH-1:0]  nxt_b;
    logic              pass_end;

    // acc <- (2*acc + y_bit*x) mod m, with acc, x < m
    function automatic logic [WIDTH-1:0] f_step(
        input logic [WIDTH-1:0] acc,
        input logic [WIDTH-1:0] x,
        input logic [WIDTH-1:0] m,
        input logic             y_bit
    );
        logic [WIDTH+1:0] t_sum;
        logic [WIDTH+1:0] m1;
        logic [WIDTH+1:0] m2;
        logic [WIDTH-1:0] res;
        m1    = {2'b00, m};
        m2    = {1'b0, m, 1'b0};
        t_sum = {1'b0, acc, 1'b0} + (y_bit ? {2'b00, x} : '0);
        if (t_sum >= m2) begin
            res = WIDTH'(t_sum - m2);
        end else if (t_sum >= m1) begin
            res = WIDTH'(t_sum - m1);
        end else begin
            res = WIDTH'(t_sum);
        end
        return res;
    endfunction

    assign pass_end = (r_cnt == CW'(WIDTH - 1));
    assign x_a      = i_cmd.red_step ? WIDTH'(1) : r_res;
    assign nxt_a    = f_step(r_acc_a, x_a, r_mod, r_ysh[WIDTH-1]);
    assign nxt_b    = f_step(r_acc_b, r_base, r_mod, r_ysh[WIDTH-1]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base  <= i_data.base[WIDTH-1:0];
            r_ysh   <= i_data.base[WIDTH-1:0];
            r_mod   <= i_data.modulus[WIDTH-1:0];
            r_exp   <= i_data.exponent;
            r_err   <= (i_data.modulus[WIDTH-1:0] == '0);
            r_acc_a <= '0;
            r_acc_b <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.red_step || i_cmd.mul_step) begin
            if (pass_end) begin
                r_acc_a <= '0;
                r_acc_b <= '0;
                r_cnt   <= '0;
                if (i_cmd.red_step) begin
                    r_base <= nxt_a;
                    r_ysh  <= nxt_a;
                    r_res  <= (r_mod == WIDTH'(1)) ? '0 : WIDTH'(1);
                end else begin
                    if (r_exp[0]) begin
                        r_res <= nxt_a;
                    end
                    r_base <= nxt_b;
                    r_ysh  <= nxt_b;
                    r_exp  <= r_exp >> 1;
                end
            end else begin
                r_acc_a <= nxt_a;
                r_acc_b <= nxt_b;
                r_ysh   <= r_ysh << 1;
                r_cnt   <= r_cnt + CW'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_out.power       <= r_err ? '0 : DATA_W'(r_res);
            r_out.bad_modulus <= r_err;
        end
    end

    assign o_stat.mod_zero = (r_mod == '0);
    assign o_stat.exp_zero = (r_exp == '0);
    assign o_stat.exp_last = (r_exp[DATA_W-1:1] == '0);
    assign o_stat.pass_end = pass_end;
    assign o_data          = r_out;

endmodule

// File: sv/modular_exponentiation.sv
// top level of the modular exponentiation block
//
//   channel  direction  handshake          word
//   input    in         i_valid / o_ready  i_data  (base, exponent, modulus)
//   output   out        o_valid / i_ready  o_data  (power, bad_modulus)
//
// per word: a load step, one reduction pass, one square-and-multiply pass per
// bit of the exponent's length, then the result handoff; a zero modulus skips
// the passes; two serial mod-multiply lanes do product and square side by side
// one word in flight; a new word is taken while the last result waits in o_data
// reset is synchronous, active low, and clears the sequencer and o_valid
module modular_exponentiation import mexp_pkg::*; #(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    t_ctl_cmd cmd;
    t_dp_stat stat;

    mexp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mexp_dpath #(
        .WIDTH (WIDTH)
    ) u_dpath (
        .i_clk  (i_clk),
        .i_data (i_data),
        .i_cmd  (cmd),
        .o_stat (stat),
        .o_data (o_data)
    );

endmodule

// File: sv/mexp_checker.sv
// port-level checks for the modular exponentiation block and their bind
module mexp_checker import mexp_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_word  i_data,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_word o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result word changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.bad_modulus |-> o_data.power == '0)
        else $error("bad modulus with nonzero power");

    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second word taken while one is in work");

    a_zero_mod_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.modulus == '0 |=> ##1 !o_ready)
        else $error("zero modulus sequencing wrong");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
